/* src/http_response_header_parser_macros.svh */
// Assertion macros for the HTTP response header parser.
`ifndef HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define HRHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/hrhp_pkg.sv */
`timescale 1ns / 1ps

package hrhp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int OUT_LEN_BITS    = 32;
  localparam int OUT_DATA_BITS   = 48;

  typedef struct packed {
    logic                    length_error;
    logic [OUT_LEN_BITS-1:0] content_length;
    logic                    status_ok;
    logic                    headers_done;
    logic [7:0]              body_byte;
    logic                    body_valid;
  } result_t;

endpackage

/* src/http_response_header_parser.sv */
`timescale 1ns / 1ps
// HTTP response header parser.
// in_*  : one response byte per word; in_tuser set clears all parser state
//         before that byte is handled (start of a new response).
// out_* : one result word per input word, in order. out_tuser flags a body
//         byte; out_tdata carries the byte and the sticky header status.
// A word accepted on in_* passes through the input register, then the parser
// state update into the result register, before it is presented on out_*.
// Throughput: one word per clock while the result buffer has room. The parser
// state (line scan, key match, decimal accumulator) advances once per word.
// A two-entry result buffer holds finished words while the receiver stalls;
// in_tready drops only when both entries are full and the input register
// holds a word, and the stream resumes without loss once out_tready returns.
// Reset (rst_n low, synchronous) empties the pipeline and returns the parser
// to the header phase with all flags and the length cleared.
module http_response_header_parser #(
  parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // [7:0] in_byte
  input  logic                               in_tuser,  // [0] new_response
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] body_byte, [8] headers_done, [9] status_ok,
  // [41:10] content_length, [42] length_error, [47:43] zero
  output logic [hrhp_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                               out_tuser  // [0] body_valid
);
  import hrhp_pkg::*;

  `include "http_response_header_parser_macros.svh"

  logic       a_v_r;
  logic [7:0] a_byte_r;
  logic       a_new_r;
  logic       a_go;
  logic       skid_full;
  result_t    core_res;
  result_t    out_res;

  assign a_go      = a_v_r && !skid_full;
  assign in_tready = !a_v_r || !skid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_tready) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_byte_r <= in_tdata;
      a_new_r  <= in_tuser;
    end
  end

  hrhp_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (a_go),
    .byte_i (a_byte_r),
    .new_i  (a_new_r),
    .result (core_res)
  );

  hrhp_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (a_go),
    .push_data (core_res),
    .full      (skid_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tuser = out_res.body_valid;
  assign out_tdata = {5'd0, out_res.length_error, out_res.content_length,
                      out_res.status_ok, out_res.headers_done, out_res.body_byte};

  `HRHP_ASSERT_NOW(a_body_after_headers, out_tvalid && out_tuser, out_tdata[8],
    "body byte before end of headers")
  `HRHP_ASSERT_NOW(a_body_byte_zero, out_tvalid && !out_tuser, out_tdata[7:0] == 8'd0,
    "non-body result carries a nonzero byte")
  `HRHP_ASSERT_NOW(a_stall_when_full, skid_full && a_v_r, !in_tready,
    "input accepted while result buffer full")
  `HRHP_ASSERT_NEXT(a_full_holds_output, skid_full && !out_tready, out_tvalid && skid_full,
    "buffered result lost during stall")

endmodule

/* src/hrhp_core.sv */
`timescale 1ns / 1ps

module hrhp_core #(
  parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_i,
  input  logic              new_i,
  output hrhp_pkg::result_t result
);
  import hrhp_pkg::*;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [3:0] KEY_LEN  = 4'd14;
  localparam logic [2:0] OK_LEN   = 3'd6;
  localparam int         PROD_W   = LENGTH_BITS + 4;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    case (pos)
      4'd0:    key_char = "c";
      4'd1:    key_char = "o";
      4'd2:    key_char = "n";
      4'd3:    key_char = "t";
      4'd4:    key_char = "e";
      4'd5:    key_char = "n";
      4'd6:    key_char = "t";
      4'd7:    key_char = "-";
      4'd8:    key_char = "l";
      4'd9:    key_char = "e";
      4'd10:   key_char = "n";
      4'd11:   key_char = "g";
      4'd12:   key_char = "t";
      4'd13:   key_char = "h";
      default: key_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ok_char(input logic [2:0] pos);
    case (pos)
      3'd0:    ok_char = "2";
      3'd1:    ok_char = "0";
      3'd2:    ok_char = "0";
      3'd3:    ok_char = " ";
      3'd4:    ok_char = "O";
      3'd5:    ok_char = "K";
      default: ok_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  phase_t                 phase_r, phase_nxt;
  logic                   line_nonempty_r, line_nonempty_nxt;
  logic                   after_cr_r, after_cr_nxt;
  logic [2:0]             ok_pos_r, ok_pos_nxt;
  logic                   ok_found_r, ok_found_nxt;
  logic [3:0]             key_pos_r, key_pos_nxt;
  logic                   key_mismatch_r, key_mismatch_nxt;
  logic                   colon_seen_r, colon_seen_nxt;
  logic                   value_started_r, value_started_nxt;
  logic [LENGTH_BITS-1:0] value_acc_r, value_acc_nxt;
  logic                   value_bad_r, value_bad_nxt;
  logic                   ok_flag_r, ok_flag_nxt;
  logic [LENGTH_BITS-1:0] length_r, length_nxt;
  logic                   error_flag_r, error_flag_nxt;
  logic                   body;
  logic [PROD_W-1:0]      prod;
  logic [63:0]            len_ext;

  always_comb begin
    phase_nxt         = phase_r;
    line_nonempty_nxt = line_nonempty_r;
    after_cr_nxt      = after_cr_r;
    ok_pos_nxt        = ok_pos_r;
    ok_found_nxt      = ok_found_r;
    key_pos_nxt       = key_pos_r;
    key_mismatch_nxt  = key_mismatch_r;
    colon_seen_nxt    = colon_seen_r;
    value_started_nxt = value_started_r;
    value_acc_nxt     = value_acc_r;
    value_bad_nxt     = value_bad_r;
    ok_flag_nxt       = ok_flag_r;
    length_nxt        = length_r;
    error_flag_nxt    = error_flag_r;
    body              = 1'b0;
    prod              = ({4'd0, value_acc_r} << 3) + ({4'd0, value_acc_r} << 1)
                        + PROD_W'(byte_i - CH_ZERO);

    if (new_i) begin
      phase_nxt         = PH_HEADER;
      line_nonempty_nxt = 1'b0;
      after_cr_nxt      = 1'b0;
      ok_pos_nxt        = '0;
      ok_found_nxt      = 1'b0;
      key_pos_nxt       = '0;
      key_mismatch_nxt  = 1'b0;
      colon_seen_nxt    = 1'b0;
      value_started_nxt = 1'b0;
      value_acc_nxt     = '0;
      value_bad_nxt     = 1'b0;
      ok_flag_nxt       = 1'b0;
      length_nxt        = '0;
      error_flag_nxt    = 1'b0;
      prod              = PROD_W'(byte_i - CH_ZERO);
    end

    case (phase_nxt)
      PH_HEADER: begin
        if (byte_i == CH_LF || (!after_cr_nxt && byte_i == CH_CR)) begin
          if (byte_i == CH_LF) begin
            after_cr_nxt = 1'b0;
          end else if (!line_nonempty_nxt) begin
            phase_nxt = PH_SKIP;
          end else begin
            after_cr_nxt = 1'b1;
            if (ok_found_nxt) begin
              ok_flag_nxt = 1'b1;
            end else if (colon_seen_nxt && !key_mismatch_nxt && key_pos_nxt == KEY_LEN
                         && value_started_nxt) begin
              if (value_bad_nxt) begin
                error_flag_nxt = 1'b1;
              end else begin
                length_nxt = value_acc_nxt;
              end
            end
          end
          line_nonempty_nxt = 1'b0;
          ok_pos_nxt        = '0;
          ok_found_nxt      = 1'b0;
          key_pos_nxt       = '0;
          key_mismatch_nxt  = 1'b0;
          colon_seen_nxt    = 1'b0;
          value_started_nxt = 1'b0;
          value_acc_nxt     = '0;
          value_bad_nxt     = 1'b0;
        end else if (!after_cr_nxt) begin
          line_nonempty_nxt = 1'b1;
          if (!ok_found_nxt) begin
            if (ok_pos_nxt < OK_LEN && byte_i == ok_char(ok_pos_nxt)) begin
              ok_pos_nxt = ok_pos_nxt + 3'd1;
            end else begin
              ok_pos_nxt = (byte_i == CH_TWO) ? 3'd1 : 3'd0;
            end
            if (ok_pos_nxt >= OK_LEN) begin
              ok_found_nxt = 1'b1;
            end
          end
          if (!colon_seen_nxt) begin
            if (byte_i == CH_COLON) begin
              colon_seen_nxt = 1'b1;
            end else if (key_pos_nxt < KEY_LEN && fold(byte_i) == key_char(key_pos_nxt)) begin
              key_pos_nxt = key_pos_nxt + 4'd1;
            end else begin
              key_mismatch_nxt = 1'b1;
            end
          end else if (value_started_nxt || byte_i != CH_SPACE) begin
            value_started_nxt = 1'b1;
            if (!value_bad_nxt) begin
              if (byte_i >= CH_ZERO && byte_i <= CH_NINE
                  && prod[PROD_W-1:LENGTH_BITS] == 4'd0) begin
                value_acc_nxt = prod[LENGTH_BITS-1:0];
              end else begin
                value_bad_nxt = 1'b1;
              end
            end
          end
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_BODY;
      end
      default: begin
        body = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEADER;
      line_nonempty_r <= 1'b0;
      after_cr_r      <= 1'b0;
      ok_pos_r        <= '0;
      ok_found_r      <= 1'b0;
      key_pos_r       <= '0;
      key_mismatch_r  <= 1'b0;
      colon_seen_r    <= 1'b0;
      value_started_r <= 1'b0;
      value_acc_r     <= '0;
      value_bad_r     <= 1'b0;
      ok_flag_r       <= 1'b0;
      length_r        <= '0;
      error_flag_r    <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      line_nonempty_r <= line_nonempty_nxt;
      after_cr_r      <= after_cr_nxt;
      ok_pos_r        <= ok_pos_nxt;
      ok_found_r      <= ok_found_nxt;
      key_pos_r       <= key_pos_nxt;
      key_mismatch_r  <= key_mismatch_nxt;
      colon_seen_r    <= colon_seen_nxt;
      value_started_r <= value_started_nxt;
      value_acc_r     <= value_acc_nxt;
      value_bad_r     <= value_bad_nxt;
      ok_flag_r       <= ok_flag_nxt;
      length_r        <= length_nxt;
      error_flag_r    <= error_flag_nxt;
    end
  end

  assign len_ext = 64'(length_nxt);

  always_comb begin
    result.body_valid     = body;
    result.body_byte      = body ? byte_i : 8'd0;
    result.headers_done   = (phase_nxt != PH_HEADER);
    result.status_ok      = ok_flag_nxt;
    result.content_length = len_ext[OUT_LEN_BITS-1:0];
    result.length_error   = error_flag_nxt;
  end

endmodule

/* src/hrhp_out_skid.sv */
`timescale 1ns / 1ps

module hrhp_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrhp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output hrhp_pkg::result_t out_data
);
  import hrhp_pkg::*;

  logic    main_v_r;
  logic    skid_v_r;
  result_t main_r;
  result_t skid_r;
  logic    take;

  assign take = main_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || take) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_v_r || take) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

/* bench/tb_http_response_header_parser.sv */
`timescale 1ns / 1ps

module tb_http_response_header_parser;
  import hrhp_pkg::*;

  localparam int LEN_BITS     = LENGTH_BITS_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 1250;
  localparam int KEY_CHARS    = 14;
  localparam int OK_CHARS     = 6;

  localparam logic [7:0] CR    = 8'h0D;
  localparam logic [7:0] LF    = 8'h0A;
  localparam logic [7:0] COLON = 8'h3A;
  localparam logic [7:0] SPACE = 8'h20;

  localparam logic [8*KEY_CHARS-1:0] KEY_TEXT = "content-length";
  localparam logic [8*OK_CHARS-1:0]  OK_TEXT  = "200 OK";
  localparam logic [63:0]            LEN_MAX  = {64{1'b1}} >> (64 - LEN_BITS);

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_BODY} scan_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fresh;
    logic       fixed;
    result_t    want;
  } word_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        fresh;
    logic        fixed;
    logic        valid;
    logic [7:0]  body;
    logic        done;
    logic        ok;
    logic [31:0] len;
    logic        err;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata   = 8'h00;
  logic                     in_tuser   = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;

  http_response_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  word_t    stream_words[$];
  result_t  pending_results[$];
  dir_row_t directed_rows[25];
  logic     next_fresh = 1'b0;
  logic     calm = 1'b0;
  int       accepted_words = 0;
  int       checked_words = 0;
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;

  // parser shadow state
  scan_phase_t scan_phase;
  logic        line_has_text, cr_pending, ok_in_line;
  logic [2:0]  ok_pos;
  logic [4:0]  key_pos;
  logic        key_bad, colon_hit, val_begun, val_bad;
  logic [63:0] val_acc, len_reg;
  logic        saw_ok, len_err;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_line_scan();
    line_has_text = 1'b0;
    ok_pos        = '0;
    ok_in_line    = 1'b0;
    key_pos       = '0;
    key_bad       = 1'b0;
    colon_hit     = 1'b0;
    val_begun     = 1'b0;
    val_acc       = '0;
    val_bad       = 1'b0;
  endfunction

  function automatic void clear_parser();
    scan_phase = PH_HEADER;
    cr_pending = 1'b0;
    clear_line_scan();
    saw_ok  = 1'b0;
    len_reg = '0;
    len_err = 1'b0;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] c, input logic fresh);
    result_t     r;
    logic        body;
    logic [7:0]  low;
    logic [63:0] digit;
    body = 1'b0;
    if (fresh) clear_parser();
    case (scan_phase)
      PH_HEADER: begin
        if (c == LF) begin
          cr_pending = 1'b0;
          clear_line_scan();
        end else if (cr_pending) begin
          // dropped until LF
        end else if (c == CR) begin
          if (!line_has_text) begin
            scan_phase = PH_SKIP;
          end else begin
            if (ok_in_line) begin
              saw_ok = 1'b1;
            end else if (colon_hit && !key_bad && key_pos == KEY_CHARS && val_begun) begin
              if (val_bad) len_err = 1'b1;
              else len_reg = val_acc;
            end
            cr_pending = 1'b1;
          end
          clear_line_scan();
        end else begin
          line_has_text = 1'b1;
          if (!ok_in_line) begin
            if (int'(ok_pos) < OK_CHARS && c == OK_TEXT[8*(OK_CHARS-1-int'(ok_pos)) +: 8])
              ok_pos = ok_pos + 3'd1;
            else
              ok_pos = (c == OK_TEXT[8*OK_CHARS-1 -: 8]) ? 3'd1 : 3'd0;
            if (int'(ok_pos) >= OK_CHARS) ok_in_line = 1'b1;
          end
          if (!colon_hit) begin
            low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
            if (c == COLON)
              colon_hit = 1'b1;
            else if (int'(key_pos) < KEY_CHARS &&
                     low == KEY_TEXT[8*(KEY_CHARS-1-int'(key_pos)) +: 8])
              key_pos = key_pos + 5'd1;
            else
              key_bad = 1'b1;
          end else if (val_begun || c != SPACE) begin
            val_begun = 1'b1;
            if (!val_bad) begin
              if (c >= "0" && c <= "9") begin
                digit = {56'd0, c - 8'h30};
                if (val_acc > (LEN_MAX - digit) / 10) val_bad = 1'b1;
                else val_acc = val_acc * 10 + digit;
              end else begin
                val_bad = 1'b1;
              end
            end
          end
        end
      end
      PH_SKIP: scan_phase = PH_BODY;
      default: body = 1'b1;
    endcase
    r.body_valid     = body;
    r.body_byte      = body ? c : 8'h00;
    r.headers_done   = (scan_phase != PH_HEADER);
    r.status_ok      = saw_ok;
    r.content_length = len_reg[31:0];
    r.length_error   = len_err;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("valid=%b byte=%h done=%b ok=%b len=%0d err=%b", r.body_valid,
                     r.body_byte, r.headers_done, r.status_ok, r.content_length,
                     r.length_error);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    word_t w;
    w       = '0;
    w.data  = b;
    w.fresh = next_fresh;
    next_fresh = 1'b0;
    stream_words.push_back(w);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_line_end();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      put_byte(LF);
    end else if (k == 1) begin
      put_byte(CR);
      put_byte(CR);
      put_byte(LF);
    end else if (k == 2) begin
      put_byte(CR);
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
      put_byte(LF);
    end else begin
      put_byte(CR);
      put_byte(LF);
    end
  endtask

  task automatic put_status_line();
    put_text("HTTP/1.0 ");
    case ($urandom_range(0, 4))
      0, 1: put_text("200 OK");
      2: put_text("404 Not Found");
      3: put_text("20200 OK");
      default: put_text("200 Ok");
    endcase
    if ($urandom_range(0, 1)) put_text(" x");
    put_line_end();
  endtask

  task automatic put_length_line();
    string key;
    case ($urandom_range(0, 9))
      0: key = "content-lengt";
      1: key = "content-lengths";
      2: key = " content-length";
      3: key = "content_length";
      default: key = "content-length";
    endcase
    for (int i = 0; i < key.len(); i++)
      put_byte((key[i] >= "a" && key[i] <= "z" && $urandom_range(0, 1)) ?
               key[i] - 8'd32 : key[i]);
    put_byte(COLON);
    repeat ($urandom_range(0, 3)) put_byte(SPACE);
    case ($urandom_range(0, 15))
      0, 1, 2, 3: put_text($sformatf("%0d", $urandom_range(0, 99999)));
      4, 5: put_text($sformatf("%0d", $urandom()));
      6: put_text("4294967295");
      7: put_text("4294967296");
      8: put_text("123456789012");
      9: put_text("0000000000000000042");
      10: ;
      11: put_text($sformatf("%0d ", $urandom_range(0, 999)));
      12: put_text($urandom_range(0, 1) ? "+7" : "-7");
      13: put_text("12:34");
      14: put_text("200 OK");
      default: begin
        put_text($sformatf("%0d", $urandom_range(0, 99)));
        put_byte(8'($urandom_range(0, 255)));
      end
    endcase
    put_line_end();
  endtask

  task automatic put_other_line();
    if ($urandom_range(0, 1)) begin
      put_text("Server: ");
      repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(32, 126)));
    end else begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
    end
    put_line_end();
  endtask

  task automatic put_response();
    next_fresh = 1'b1;
    if ($urandom_range(0, 9) != 0) put_status_line();
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1)) put_length_line();
      else put_other_line();
    end
    // headers cut off by the next response
    if ($urandom_range(0, 9) == 0) return;
    put_byte(CR);
    put_byte(($urandom_range(0, 3) != 0) ? LF : 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, ($urandom_range(0, 9) == 0) ? 200 : 30))
      put_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : run
    word_t w;
    int    gap;
    clear_parser();
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{"2",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{"0",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{"0",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{" ",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{"O",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{"K",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CR,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CR,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{"x",   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{COLON, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CR,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{CR,    1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 32'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 32'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 32'd0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 32'd0, 1'b0},
      '{CR,    1'b0, 1'b1, 1'b1, CR,    1'b1, 1'b1, 32'd0, 1'b0},
      '{LF,    1'b0, 1'b1, 1'b1, LF,    1'b1, 1'b1, 32'd0, 1'b0},
      '{"C",   1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0},
      '{LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 1'b0}
    };
    foreach (directed_rows[i]) begin
      w                     = '0;
      w.data                = directed_rows[i].data;
      w.fresh               = directed_rows[i].fresh;
      w.fixed               = directed_rows[i].fixed;
      w.want.body_valid     = directed_rows[i].valid;
      w.want.body_byte      = directed_rows[i].body;
      w.want.headers_done   = directed_rows[i].done;
      w.want.status_ok      = directed_rows[i].ok;
      w.want.content_length = directed_rows[i].len;
      w.want.length_error   = directed_rows[i].err;
      stream_words.push_back(w);
    end
    while (stream_words.size() < $size(directed_rows) + RANDOM_WORDS) begin
      if ($urandom_range(0, 19) == 0) begin
        next_fresh = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_response();
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stream_words[i]) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 3);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= stream_words[i].data;
      in_tuser  <= stream_words[i].fresh;
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;
    while (accepted_words < stream_words.size() || pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm <= !calm;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(19, 39) : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : track_input
    result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      r = parse_byte(in_tdata, in_tuser);
      if (stream_words[accepted_words].fixed) r = stream_words[accepted_words].want;
      pending_results.push_back(r);
      accepted_words++;
    end
  end

  always @(posedge clk) begin : check_output
    result_t want, got;
    string   bad;
    if (rst_n && out_tvalid && out_tready) begin
      got.body_valid     = out_tuser;
      got.body_byte      = out_tdata[7:0];
      got.headers_done   = out_tdata[8];
      got.status_ok      = out_tdata[9];
      got.content_length = out_tdata[41:10];
      got.length_error   = out_tdata[42];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word: %s", show(got));
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (got.body_valid !== want.body_valid) bad = {bad, " body_valid"};
        if (got.body_byte !== want.body_byte) bad = {bad, " body_byte"};
        if (got.headers_done !== want.headers_done) bad = {bad, " headers_done"};
        if (got.status_ok !== want.status_ok) bad = {bad, " status_ok"};
        if (got.content_length !== want.content_length) bad = {bad, " content_length"};
        if (got.length_error !== want.length_error) bad = {bad, " length_error"};
        if (bad != "") begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("word %0d mismatch in%s", checked_words, bad);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
      checked_words++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
